// File: sv/slpe_pkg.sv
// Package for the status LED pattern engine.
// Holds action, op and overlay codes, register indexes and shared item types.
// No dependencies.
package slpe_pkg;

  // Input action codes
  localparam logic [2:0] ACT_RENDER  = 3'd0;
  localparam logic [2:0] ACT_LINK    = 3'd1;
  localparam logic [2:0] ACT_OVERLAY = 3'd2;
  localparam logic [2:0] ACT_MODE    = 3'd3;
  localparam logic [2:0] ACT_PROV    = 3'd4;

  // Classified operations handed from front to back
  localparam logic [2:0] OP_NOP     = 3'd0;
  localparam logic [2:0] OP_RENDER  = 3'd1;
  localparam logic [2:0] OP_LINK    = 3'd2;
  localparam logic [2:0] OP_OVERLAY = 3'd3;
  localparam logic [2:0] OP_MODE    = 3'd4;
  localparam logic [2:0] OP_PROV    = 3'd5;

  // Overlay kinds
  localparam logic [3:0] OVL_PING      = 4'd0;
  localparam logic [3:0] OVL_ERROR     = 4'd1;
  localparam logic [3:0] OVL_SPK_ON    = 4'd2;
  localparam logic [3:0] OVL_SPK_OFF   = 4'd3;
  localparam logic [3:0] OVL_MUTE_ON   = 4'd4;
  localparam logic [3:0] OVL_MUTE_OFF  = 4'd5;
  localparam logic [3:0] OVL_VOLUME    = 4'd6;
  localparam logic [3:0] OVL_REBOOT    = 4'd7;
  localparam logic [3:0] OVL_PROV_ACC  = 4'd8;
  localparam logic [3:0] OVL_PROV_REJ  = 4'd9;
  localparam logic [3:0] OVL_PROV_SAVE = 4'd10;
  localparam logic [3:0] OVL_PROV_TMO  = 4'd11;
  localparam logic [3:0] OVL_NONE      = 4'd15;

  // Base modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_LISTEN = 2'd1;
  localparam logic [1:0] MODE_THINK  = 2'd2;
  localparam logic [1:0] MODE_SPEAK  = 2'd3;

  localparam logic [6:0] VOL_MAX = 7'd100;

  // Configuration register indexes and reset values
  localparam logic CFG_FRAME = 1'b0;
  localparam logic CFG_GRACE = 1'b1;
  localparam logic [9:0]  FRAME_RESET = 10'd25;
  localparam logic [15:0] GRACE_RESET = 16'd3000;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] now;
    logic        flag;
    logic [3:0]  kind;
    logic [6:0]  vol;
    logic [1:0]  mode;
  } item_t;

  typedef struct packed {
    logic        strobe;
    logic [11:0] colour;
  } result_t;

  typedef struct packed {
    logic [9:0]  frame;
    logic [15:0] grace;
  } cfg_t;

endpackage

// File: sv/status_led_pattern_engine_unit.sv
// Top level of the status LED pattern engine: configuration registers,
// front-end queue and back-end executor. Depends on slpe_pkg, slpe_front, slpe_back.
//
// Input channel: drive the item fields with push high; the beat is taken at a
// clock edge where full is low. Result channel: while empty is low the oldest
// result (write_strobe, red, green, blue) is shown; pop high takes the beat.
// Every input beat gives exactly one result beat, in order.
// Configuration: cfg_we with cfg_index 0 (frame interval) or 1 (grace time)
// writes cfg_data at that edge; write only while the block is idle.
// Rate: link, overlay, mode, provisioning and ignored items run one per cycle
// in the back end while the result queue has room. A render tick is launched,
// then runs in the remainder unit (reciprocal multiply, then multiply back and
// subtract, each registered), then finishes; no other item is taken meanwhile.
// With empty queues a result passes through the item queue and the result queue.
// The item queue holds QUEUE_DEPTH beats so input keeps flowing while the
// back end is busy; when the result side stalls, up to OUT_DEPTH results wait
// and the back end then holds until pop frees room.
// Reset: control, pattern and configuration state return to idle values, colour dark, queues empty.
module status_led_pattern_engine_unit
  import slpe_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4,
  parameter int OUT_DEPTH   = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  action,
  input  logic [31:0] now_ms,
  input  logic        flag,
  input  logic [3:0]  overlay_kind,
  input  logic [6:0]  overlay_value,
  input  logic [1:0]  mode,
  output logic        empty,
  input  logic        pop,
  output logic        write_strobe,
  output logic [3:0]  red,
  output logic [3:0]  green,
  output logic [3:0]  blue,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  cfg_t    cfg;
  item_t   q_item;
  logic    q_valid, q_pop;
  result_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame <= FRAME_RESET;
      cfg.grace <= GRACE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME: cfg.frame <= cfg_data[9:0];
        CFG_GRACE: cfg.grace <= cfg_data;
        default: ;
      endcase
    end
  end

  slpe_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .action        (action),
    .now_ms        (now_ms),
    .flag          (flag),
    .overlay_kind  (overlay_kind),
    .overlay_value (overlay_value),
    .mode          (mode),
    .q_item        (q_item),
    .q_valid       (q_valid),
    .q_pop         (q_pop)
  );

  slpe_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  assign write_strobe = res.strobe;
  assign red          = res.colour[11:8];
  assign green        = res.colour[7:4];
  assign blue         = res.colour[3:0];
endmodule

// File: sv/slpe_fifo.sv
// Small register FIFO used for the item queue and the result queue.
// Standalone; DEPTH must be a power of two.
module slpe_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;
  logic          do_wr, do_rd;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rp];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_wr) wp <= wp + 1'b1;
      if (do_rd) rp <= rp + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) mem[wp] <= wdata;
  end
endmodule

// File: sv/slpe_front.sv
// Front end: accepts input beats, classifies the action, saturates the volume
// and queues the item. Depends on slpe_pkg and slpe_fifo.
module slpe_front
  import slpe_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  action,
  input  logic [31:0] now_ms,
  input  logic        flag,
  input  logic [3:0]  overlay_kind,
  input  logic [6:0]  overlay_value,
  input  logic [1:0]  mode,
  output item_t       q_item,
  output logic        q_valid,
  input  logic        q_pop
);
  item_t in_item;
  logic  q_empty;

  // classify the action
  always_comb begin
    in_item.now  = now_ms;
    in_item.flag = flag;
    in_item.kind = overlay_kind;
    in_item.vol  = (overlay_value > VOL_MAX) ? VOL_MAX : overlay_value;
    in_item.mode = mode;
    case (action)
      ACT_RENDER:  in_item.op = OP_RENDER;
      ACT_LINK:    in_item.op = OP_LINK;
      ACT_OVERLAY: in_item.op = (overlay_kind <= OVL_PROV_TMO) ? OP_OVERLAY : OP_NOP;
      ACT_MODE:    in_item.op = OP_MODE;
      ACT_PROV:    in_item.op = OP_PROV;
      default:     in_item.op = OP_NOP;
    endcase
  end

  slpe_fifo #(.W($bits(item_t)), .DEPTH(DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .wdata (in_item),
    .rd    (q_pop),
    .rdata (q_item),
    .full  (full),
    .empty (q_empty)
  );

  assign q_valid = !q_empty;
endmodule

// File: sv/slpe_modser.sv
// Remainder unit: x mod dv by reciprocal multiplication, a registered quotient estimate then a registered remainder.
// Standalone; dv must be one of the pattern periods 1000, 1200, 1800 or 2200.
module slpe_modser (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] x,
  input  logic [11:0] dv,
  output logic        busy,
  output logic [11:0] rem
);
  // floor(2^32 / period)
  localparam logic [22:0] RCP_1000 = 23'd4294967;
  localparam logic [22:0] RCP_1200 = 23'd3579139;
  localparam logic [22:0] RCP_1800 = 23'd2386092;
  localparam logic [22:0] RCP_2200 = 23'd1952257;

  logic [31:0] xr;
  logic [11:0] dvr;
  logic [22:0] rcp, rcp_sel;
  logic [54:0] prod;
  logic [22:0] q;
  logic [31:0] qd;
  logic [12:0] r;
  logic [1:0]  cnt;

  // reciprocal for the requested period
  always_comb begin
    case (dv)
      12'd1000: rcp_sel = RCP_1000;
      12'd1200: rcp_sel = RCP_1200;
      12'd1800: rcp_sel = RCP_1800;
      12'd2200: rcp_sel = RCP_2200;
      default:  rcp_sel = '0;
    endcase
  end

  // quotient estimate is exact or one low; remainder estimate below 2*dv
  assign prod = 55'(xr) * 55'(rcp);
  assign qd   = 32'(q) * 32'(dvr);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= 2'd2;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr  <= x;
      dvr <= dv;
      rcp <= rcp_sel;
    end
    if (cnt == 2'd2) q <= prod[54:32];
    if (cnt == 2'd1) r <= 13'(xr - qd);
  end

  // final correction by one subtract
  assign busy = (cnt != '0);
  assign rem  = (r >= {1'b0, dvr}) ? 12'(r - {1'b0, dvr}) : r[11:0];
endmodule

// File: sv/slpe_back.sv
// Back end: holds pattern state, executes queued items, renders colours and
// queues results. Depends on slpe_pkg, slpe_modser and slpe_fifo.
module slpe_back
  import slpe_pkg::*;
#(
  parameter int OUT_DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   q_item,
  input  logic    q_valid,
  output logic    q_pop,
  input  cfg_t    cfg,
  output logic    empty,
  input  logic    pop,
  output result_t res
);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_MOD  = 1'b1;

  localparam logic [2:0] SEL_NONE   = 3'd0;
  localparam logic [2:0] SEL_SPEAK  = 3'd1;
  localparam logic [2:0] SEL_LISTEN = 3'd2;
  localparam logic [2:0] SEL_THINK  = 3'd3;
  localparam logic [2:0] SEL_PROV   = 3'd4;
  localparam logic [2:0] SEL_AMBER  = 3'd5;

  // floor(d * mul / dv) for small results, by constant threshold compares
  function automatic logic [3:0] scale(logic [11:0] d, int unsigned mul, int unsigned dv);
    logic [3:0] q;
    q = '0;
    for (int unsigned k = 1; k < 16; k++) begin
      if (32'(d) * mul >= dv * k) q = 4'(k);
    end
    return q;
  endfunction

  logic        state;
  logic [1:0]  base_mode;
  logic        prov_on;
  logic        link_av;
  logic [31:0] lost_time;
  logic        loss_rep;
  logic [3:0]  active_ovl;
  logic [31:0] ovl_start;
  logic [6:0]  ovl_vol;
  logic [11:0] last_col;
  logic [31:0] last_wt;

  item_t       cur;
  logic [2:0]  cur_sel;
  logic        cur_amb;

  logic [31:0] since;
  logic        amb;
  logic [2:0]  sel;
  logic [31:0] mx;
  logic [11:0] mdv;
  logic        mod_start, mod_busy;
  logic [11:0] ph;

  logic [31:0] e;
  logic [9:0]  ev, dref;
  logic        ovl_run;
  logic [11:0] ovl_col, base_col, fin_col;
  logic        fin_write;
  logic        out_full, res_push, take_item, finish;
  result_t     res_data;

  // pick the base pattern and the remainder it needs
  always_comb begin
    since = q_item.now - lost_time;
    amb   = !link_av && (since >= {16'b0, cfg.grace});
    mx    = q_item.now;
    mdv   = 12'd1200;
    if (base_mode == MODE_SPEAK) sel = SEL_SPEAK;
    else if (base_mode == MODE_LISTEN) sel = SEL_LISTEN;
    else if (base_mode == MODE_THINK) begin
      sel = SEL_THINK;
      mdv = 12'd1000;
    end else if (prov_on) begin
      sel = SEL_PROV;
      mdv = 12'd1800;
    end else if (amb) begin
      sel = SEL_AMBER;
      mx  = since - {16'b0, cfg.grace};
      mdv = 12'd2200;
    end else sel = SEL_NONE;
  end

  assign mod_start = (state == ST_IDLE) && q_valid && (q_item.op == OP_RENDER);

  slpe_modser u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .x     (mx),
    .dv    (mdv),
    .busy  (mod_busy),
    .rem   (ph)
  );

  // base colour from the phase
  always_comb begin
    base_col = 12'h000;
    case (cur_sel)
      SEL_SPEAK: base_col = {4'd0, 4'd5, 4'd0};
      SEL_LISTEN: begin
        if (ph < 12'd180) base_col = {8'd0, 4'd10 + scale(ph, 5, 180)};
        else if (ph < 12'd760) base_col = {8'd0, 4'd15};
        else base_col = {8'd0, 4'd15 - scale(ph - 12'd760, 5, 440)};
      end
      SEL_THINK: begin
        if (ph < 12'd100) base_col = {4'd5, 4'd0, 4'd7};
        else if (ph >= 12'd200 && ph < 12'd280) base_col = {4'd3, 4'd0, 4'd4};
      end
      SEL_PROV: begin
        if (ph < 12'd100 || (ph >= 12'd220 && ph < 12'd300)) base_col = {4'd0, 4'd5, 4'd7};
      end
      SEL_AMBER: begin
        if (ph < 12'd90 || (ph >= 12'd170 && ph < 12'd240)) base_col = {4'd9, 4'd5, 4'd0};
      end
      default: base_col = 12'h000;
    endcase
  end

  // overlay colour and expiry
  always_comb begin
    e       = cur.now - ovl_start;
    ev      = e[9:0];
    dref    = '0;
    ovl_run = 1'b0;
    ovl_col = 12'h000;
    case (active_ovl)
      OVL_PING: begin
        ovl_run = (e < 32'd250);
        dref    = 10'd250 - ev;
        ovl_col = {3{scale({2'b0, dref}, 8, 250)}};
      end
      OVL_ERROR: begin
        ovl_run = (e < 32'd780);
        if (ev < 10'd110 || (ev >= 10'd180 && ev < 10'd290) || (ev >= 10'd360 && ev < 10'd470))
          ovl_col = {4'd7, 4'd0, 4'd0};
      end
      OVL_SPK_ON, OVL_SPK_OFF: begin
        ovl_run = (e < 32'd300);
        if (ev < 10'd70 || (ev >= 10'd140 && ev < 10'd240)) begin
          if (active_ovl == OVL_SPK_ON) ovl_col = {4'd0, (ev < 10'd100) ? 4'd4 : 4'd7, 4'd0};
          else ovl_col = {(ev < 10'd100) ? 4'd7 : 4'd4, 8'd0};
        end
      end
      OVL_MUTE_ON: begin
        ovl_run = (e < 32'd160);
        ovl_col = {4'd9, 4'd2, 4'd0};
      end
      OVL_MUTE_OFF: begin
        ovl_run = (e < 32'd160);
        ovl_col = {4'd0, 4'd7, 4'd0};
      end
      OVL_VOLUME: begin
        ovl_run = (e < 32'd160);
        ovl_col = {4'd0, 4'd2 + scale({5'b0, ovl_vol}, 5, 100), 4'd0};
      end
      OVL_REBOOT: begin
        ovl_run = (e < 32'd900);
        dref    = (ev < 10'd450) ? ev : 10'd900 - ev;
        ovl_col = {4'd0, 4'd2 + scale({2'b0, dref}, 10, 450), 4'd0};
      end
      OVL_PROV_ACC, OVL_PROV_SAVE: begin
        ovl_run = (e < 32'd300);
        if (ev < 10'd90 || (ev >= 10'd160 && ev < 10'd250)) ovl_col = {4'd0, 4'd7, 4'd0};
      end
      OVL_PROV_REJ: begin
        ovl_run = (e < 32'd320);
        if (ev < 10'd70 || (ev >= 10'd120 && ev < 10'd190) || (ev >= 10'd240 && ev < 10'd310))
          ovl_col = {4'd7, 4'd0, 4'd0};
      end
      OVL_PROV_TMO: begin
        ovl_run = (e < 32'd500);
        dref    = (ev < 10'd250) ? ev : 10'd500 - ev;
        ovl_col = {scale({2'b0, dref}, 9, 250), scale({2'b0, dref}, 5, 250), 4'd0};
      end
      default: ovl_run = 1'b0;
    endcase
  end

  // final colour and frame pacing
  assign fin_col   = ovl_run ? ovl_col : base_col;
  assign fin_write = (fin_col != last_col) && ((cur.now - last_wt) >= {22'b0, cfg.frame});

  assign take_item = (state == ST_IDLE) && q_valid && (q_item.op != OP_RENDER) && !out_full;
  assign finish    = (state == ST_MOD) && !mod_busy && !out_full;
  assign q_pop     = mod_start || take_item;
  assign res_push  = take_item || finish;

  always_comb begin
    if (state == ST_MOD) begin
      res_data.strobe = fin_write;
      res_data.colour = fin_write ? fin_col : last_col;
    end else begin
      res_data.strobe = 1'b0;
      res_data.colour = last_col;
    end
  end

  // control state and pattern state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      base_mode  <= MODE_IDLE;
      prov_on    <= 1'b0;
      link_av    <= 1'b1;
      lost_time  <= '0;
      loss_rep   <= 1'b0;
      active_ovl <= OVL_NONE;
      ovl_start  <= '0;
      ovl_vol    <= '0;
      last_col   <= '0;
      last_wt    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (mod_start) state <= ST_MOD;
          else if (take_item) begin
            case (q_item.op)
              OP_LINK: begin
                if (q_item.flag != link_av) begin
                  link_av <= q_item.flag;
                  if (!q_item.flag) begin
                    lost_time <= q_item.now;
                    loss_rep  <= 1'b0;
                  end else if (loss_rep) begin
                    active_ovl <= OVL_PING;
                    ovl_start  <= q_item.now;
                    ovl_vol    <= '0;
                    loss_rep   <= 1'b0;
                  end
                end
              end
              OP_OVERLAY: begin
                active_ovl <= q_item.kind;
                ovl_start  <= q_item.now;
                ovl_vol    <= q_item.vol;
              end
              OP_MODE: base_mode <= q_item.mode;
              OP_PROV: prov_on <= q_item.flag;
              default: ;
            endcase
          end
        end
        ST_MOD: begin
          if (finish) begin
            state <= ST_IDLE;
            if (cur_amb) loss_rep <= 1'b1;
            if (!ovl_run) active_ovl <= OVL_NONE;
            if (fin_write) begin
              last_col <= fin_col;
              last_wt  <= cur.now;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // render tick held while the remainder runs
  always_ff @(posedge clk) begin
    if (mod_start) begin
      cur     <= q_item;
      cur_sel <= sel;
      cur_amb <= amb && (sel == SEL_AMBER);
    end
  end

  slpe_fifo #(.W($bits(result_t)), .DEPTH(OUT_DEPTH)) u_out (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res_data),
    .rd    (pop),
    .rdata (res),
    .full  (out_full),
    .empty (empty)
  );
endmodule

// File: sv/slpe_checker.sv
// Port-level checker for the status LED pattern engine, bound to the top level.
// Standalone; tracks the colour of the last result taken.
module slpe_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       write_strobe,
  input logic [3:0] red,
  input logic [3:0] green,
  input logic [3:0] blue
);
  logic [11:0] seen_col;

  // colour of the last result beat, dark after reset
  always_ff @(posedge clk) begin
    if (rst) seen_col <= '0;
    else if (pop && !empty) seen_col <= {red, green, blue};
  end

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_not_full_after_reset: assert property (@(posedge clk) rst |=> !full)
    else $error("item queue full after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable({write_strobe, red, green, blue})))
    else $error("waiting result changed");

  a_no_strobe_holds_colour: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !write_strobe) |-> ({red, green, blue} == seen_col))
    else $error("colour changed without write strobe");

  a_strobe_new_colour: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && write_strobe) |-> ({red, green, blue} != seen_col))
    else $error("write strobe with unchanged colour");
endmodule

bind status_led_pattern_engine_unit slpe_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .write_strobe (write_strobe),
  .red          (red),
  .green        (green),
  .blue         (blue)
);

// File: tb/sv/testbench.sv
// Testbench for status_led_pattern_engine_unit: directed and random beats with
// an in-bench LED colour predictor and an in-order result scoreboard.
// Depends on slpe_pkg and the RTL top level.
module testbench;
  import slpe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [2:0] action = '0;
  logic [31:0] now_ms = '0;
  logic flag = 1'b0;
  logic [3:0] overlay_kind = '0;
  logic [6:0] overlay_value = '0;
  logic [1:0] mode = '0;
  logic empty;
  logic pop = 1'b0;
  logic write_strobe;
  logic [3:0] red, green, blue;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  status_led_pattern_engine_unit DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state
  logic [9:0]  frame_ms;
  logic [15:0] grace_ms;
  logic [1:0]  pm_mode;
  logic        pm_prov;
  logic        pm_link;
  logic [31:0] pm_lost_at;
  logic        pm_reported;
  logic [3:0]  pm_ovl;
  logic [31:0] pm_ovl_at;
  logic [6:0]  pm_vol;
  logic [11:0] pm_colour;
  logic [31:0] pm_written_at;

  result_t colour_queue[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int strobes_seen = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  logic [31:0] clock_ms = 32'd0;

  function automatic logic [11:0] mk(int r, int g, int b);
    return {4'(r), 4'(g), 4'(b)};
  endfunction

  function automatic bit in_win(logic [31:0] t, logic [31:0] from, logic [31:0] len);
    return t >= from && t < from + len;
  endfunction

  function automatic int ramp(logic [31:0] e, int peak);
    logic [31:0] d;
    if (e >= 500) return 0;
    d = (e < 250) ? e : 500 - e;
    return (d * peak) / 250;
  endfunction

  // Base pattern; may flag a reported loss
  function automatic logic [11:0] base_colour(logic [31:0] t);
    logic [31:0] ph, since;
    int lv;
    if (pm_mode == MODE_SPEAK) return mk(0, 5, 0);
    if (pm_mode == MODE_LISTEN) begin
      ph = t % 1200;
      if (ph < 180) lv = 10 + (ph * 5) / 180;
      else if (ph < 760) lv = 15;
      else lv = 15 - ((ph - 760) * 5) / 440;
      return mk(0, 0, lv);
    end
    if (pm_mode == MODE_THINK) begin
      ph = t % 1000;
      if (ph < 100) return mk(5, 0, 7);
      if (ph >= 200 && ph < 280) return mk(3, 0, 4);
      return 12'h000;
    end
    if (pm_prov) begin
      ph = t % 1800;
      if (in_win(ph, 0, 100) || in_win(ph, 220, 80)) return mk(0, 5, 7);
      return 12'h000;
    end
    if (!pm_link) begin
      since = t - pm_lost_at;
      if (since >= {16'd0, grace_ms}) begin
        pm_reported = 1'b1;
        ph = (since - grace_ms) % 2200;
        if (in_win(ph, 0, 90) || in_win(ph, 170, 70)) return mk(9, 5, 0);
      end
    end
    return 12'h000;
  endfunction

  // Overlay on top of the base; returns 0 when the overlay has run out
  function automatic bit overlay_colour(logic [31:0] e, inout logic [11:0] c);
    int v, d;
    case (pm_ovl)
      OVL_PING: begin
        if (e >= 250) return 0;
        v = ((250 - e) * 8) / 250;
        c = mk(v, v, v);
      end
      OVL_ERROR: begin
        if (e >= 780) return 0;
        c = (in_win(e, 0, 110) || in_win(e, 180, 110) || in_win(e, 360, 110)) ?
            mk(7, 0, 0) : 12'h000;
      end
      OVL_SPK_ON, OVL_SPK_OFF: begin
        if (e >= 300) return 0;
        if (in_win(e, 0, 70) || in_win(e, 140, 100)) begin
          if (pm_ovl == OVL_SPK_ON) c = mk(0, e < 100 ? 4 : 7, 0);
          else c = mk(e < 100 ? 7 : 4, 0, 0);
        end else begin
          c = 12'h000;
        end
      end
      OVL_MUTE_ON: begin
        if (e >= 160) return 0;
        c = mk(9, 2, 0);
      end
      OVL_MUTE_OFF: begin
        if (e >= 160) return 0;
        c = mk(0, 7, 0);
      end
      OVL_VOLUME: begin
        if (e >= 160) return 0;
        c = mk(0, 2 + (pm_vol * 5) / 100, 0);
      end
      OVL_REBOOT: begin
        if (e >= 900) return 0;
        d = (e < 450) ? e : 900 - e;
        c = mk(0, 2 + (d * 10) / 450, 0);
      end
      OVL_PROV_ACC, OVL_PROV_SAVE: begin
        if (e >= 300) return 0;
        c = (in_win(e, 0, 90) || in_win(e, 160, 90)) ? mk(0, 7, 0) : 12'h000;
      end
      OVL_PROV_REJ: begin
        if (e >= 320) return 0;
        c = (in_win(e, 0, 70) || in_win(e, 120, 70) || in_win(e, 240, 70)) ?
            mk(7, 0, 0) : 12'h000;
      end
      OVL_PROV_TMO: begin
        if (e >= 500) return 0;
        c = mk(ramp(e, 9), ramp(e, 5), 0);
      end
      default: return 0;
    endcase
    return 1;
  endfunction

  function automatic void start_overlay(logic [3:0] k, logic [6:0] v, logic [31:0] t);
    pm_ovl = k;
    pm_ovl_at = t;
    pm_vol = (v > VOL_MAX) ? VOL_MAX : v;
  endfunction

  function automatic void predictor_reset();
    frame_ms = FRAME_RESET;
    grace_ms = GRACE_RESET;
    pm_mode = MODE_IDLE;
    pm_prov = 0;
    pm_link = 1;
    pm_lost_at = 0;
    pm_reported = 0;
    pm_ovl = OVL_NONE;
    pm_ovl_at = 0;
    pm_vol = 0;
    pm_colour = 0;
    pm_written_at = 0;
  endfunction

  // Advance the predictor by one beat and queue the expected result
  function automatic void predict_led(logic [2:0] a, logic [31:0] t, logic f,
                                      logic [3:0] k, logic [6:0] v, logic [1:0] m);
    logic [11:0] c;
    result_t r;
    r.strobe = 0;
    case (a)
      ACT_RENDER: begin
        c = base_colour(t);
        if (pm_ovl != OVL_NONE && !overlay_colour(t - pm_ovl_at, c)) pm_ovl = OVL_NONE;
        if (c != pm_colour && (t - pm_written_at) >= {22'd0, frame_ms}) begin
          pm_colour = c;
          pm_written_at = t;
          r.strobe = 1;
        end
      end
      ACT_LINK: begin
        if (f != pm_link) begin
          pm_link = f;
          if (!f) begin
            pm_lost_at = t;
            pm_reported = 0;
          end else if (pm_reported) begin
            start_overlay(OVL_PING, 0, t);
            pm_reported = 0;
          end
        end
      end
      ACT_OVERLAY: if (k <= OVL_PROV_TMO) start_overlay(k, v, t);
      ACT_MODE: pm_mode = m;
      ACT_PROV: pm_prov = f;
      default: ;
    endcase
    r.colour = pm_colour;
    colour_queue.push_back(r);
  endfunction

  // Send one beat and wait for it to be taken; push stays high for the next beat
  task automatic send_beat(logic [2:0] a, logic [31:0] t, logic f = 0,
                           logic [3:0] k = 0, logic [6:0] v = 0, logic [1:0] m = 0);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    action <= a;
    now_ms <= t;
    flag <= f;
    overlay_kind <= k;
    overlay_value <= v;
    mode <= m;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_led(a, t, f, k, v, m);
    beats_sent++;
  endtask

  task automatic render_at(logic [31:0] t);
    send_beat(ACT_RENDER, t, 1'($urandom_range(1)), 4'($urandom_range(15)),
              7'($urandom_range(127)), 2'($urandom_range(3)));
  endtask

  task automatic drain();
    push <= 1'b0;
    while (colour_queue.size() != 0 && !timed_out) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    drain();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME) frame_ms = val[9:0];
    else grace_ms = val;
  endtask

  // Result checker
  always @(posedge clk) begin
    result_t got, want;
    if (!rst) begin
      if (pop && !empty) begin
        got = {write_strobe, red, green, blue};
        beats_checked++;
        if (write_strobe) strobes_seen++;
        if (colour_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: got %h", got);
        end else begin
          want = colour_queue.pop_front();
          if (got.strobe !== want.strobe || got.colour !== want.colour) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d: expected strobe %b rgb %h, got strobe %b rgb %h",
                       beats_checked, want.strobe, want.colour, got.strobe, got.colour);
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: cycles without any accepted beat, taken result or register write
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      timed_out = 1;
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  // Directed: every operation but link, every overlay kind, ignored codes, saturation
  task automatic test_directed();
    send_beat(ACT_RENDER, 32'd0);
    send_beat(ACT_MODE, 0, 0, 0, 0, MODE_SPEAK);
    send_beat(ACT_RENDER, 32'd10);
    send_beat(ACT_RENDER, 32'd40);
    send_beat(ACT_MODE, 0, 0, 0, 0, MODE_THINK);
    send_beat(ACT_RENDER, 32'd1050);
    send_beat(ACT_OVERLAY, 32'd2000, 0, OVL_VOLUME, 7'd127);
    send_beat(ACT_RENDER, 32'd2050);
    send_beat(ACT_OVERLAY, 32'd2100, 0, 4'd13, 7'd5);
    send_beat(ACT_RENDER, 32'd2140);
    send_beat(ACT_RENDER, 32'd2400);
    send_beat(3'd5, 32'd2500, 1, 4'd15, 7'd64, MODE_LISTEN);
    send_beat(3'd7, 32'hFFFF_FFFF, 1, 4'd15, 7'd127, 2'd3);
    send_beat(ACT_MODE, 0, 0, 0, 0, MODE_LISTEN);
    send_beat(ACT_RENDER, 32'hFFFF_FFFF);
    send_beat(ACT_MODE, 0, 0, 0, 0, MODE_IDLE);
    send_beat(ACT_PROV, 0, 1);
    send_beat(ACT_RENDER, 32'd3600);
    send_beat(ACT_PROV, 0, 0);
    for (int k = 0; k <= 11; k++) begin
      send_beat(ACT_OVERLAY, 32'd5000 + k * 1000, 0, 4'(k), 7'(k * 9));
      send_beat(ACT_RENDER, 32'd5030 + k * 1000);
    end
  endtask

  // Link loss at time zero, amber report, and the ping on recovery
  task automatic test_link_loss();
    send_beat(ACT_LINK, 32'd0, 0);
    send_beat(ACT_LINK, 32'd5, 0);
    send_beat(ACT_RENDER, 32'd3000);
    send_beat(ACT_RENDER, 32'd3200);
    send_beat(ACT_LINK, 32'd3300, 1);
    send_beat(ACT_LINK, 32'd3301, 1);
    send_beat(ACT_RENDER, 32'd3320);
    send_beat(ACT_RENDER, 32'd3600);
  endtask

  // Random sequences: mostly render ticks on a moving clock, some events
  task automatic test_random(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      clock_ms += ($urandom_range(9) == 0) ? $urandom() : $urandom_range(120);
      if (sel < 60) render_at(clock_ms);
      else if (sel < 70)
        send_beat(ACT_LINK, clock_ms, 1'($urandom_range(1)), 4'($urandom_range(15)),
                  7'($urandom_range(127)), 2'($urandom_range(3)));
      else if (sel < 82)
        send_beat(ACT_OVERLAY, clock_ms, 1'($urandom_range(1)), 4'($urandom_range(15)),
                  7'($urandom_range(127)), 2'($urandom_range(3)));
      else if (sel < 92)
        send_beat(ACT_MODE, clock_ms, 1'($urandom_range(1)), 4'($urandom_range(15)),
                  7'($urandom_range(127)), 2'($urandom_range(3)));
      else if (sel < 97)
        send_beat(ACT_PROV, clock_ms, 1'($urandom_range(1)), 4'($urandom_range(15)),
                  7'($urandom_range(127)), 2'($urandom_range(3)));
      else
        send_beat(3'($urandom_range(7)), clock_ms, 1'($urandom_range(1)),
                  4'($urandom_range(15)), 7'($urandom_range(127)), 2'($urandom_range(3)));
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    predictor_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_link_loss();
    write_reg(CFG_FRAME, 16'd0);
    write_reg(CFG_GRACE, 16'd0);
    test_link_loss();
    test_random(250);
    send_idle_pct = 52;
    write_reg(CFG_FRAME, 16'd1000);
    write_reg(CFG_GRACE, 16'd60000);
    test_random(250);
    send_idle_pct = 0;
    recv_stall_pct = 52;
    write_reg(CFG_FRAME, 16'($urandom_range(1000)));
    write_reg(CFG_GRACE, 16'($urandom_range(5000)));
    test_random(250);
    send_idle_pct = 34;
    recv_stall_pct = 34;
    write_reg(CFG_FRAME, 16'hFFFF);
    write_reg(CFG_GRACE, 16'hFFFF);
    write_reg(CFG_FRAME, 16'd1);
    write_reg(CFG_GRACE, 16'd200);
    test_random(300);
    drain();
    $display("Sent %0d beats over four idle mixes and six register settings;",
             beats_sent);
    $display("checked %0d results, %0d colour writes, %0d mismatches.",
             beats_checked, strobes_seen, mismatches);
    if (mismatches == 0 && colour_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
